>>> src/tcfr_pkg.sv
`default_nettype none
package tcfr_pkg;

  localparam int MOTOR_COUNT = 8;
  localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int POS_W = $clog2(2 * MOTOR_COUNT + 2);

  localparam logic [7:0]  FRAME_START   = 8'h5A;
  localparam logic [15:0] NEUTRAL       = 16'd1000;
  localparam logic [15:0] FORWARD_MAX   = 16'd2000;
  localparam logic [15:0] REVERSE_TOP   = 16'd1047;
  localparam logic [15:0] FORWARD_SHIFT = 16'd47;
  localparam logic [15:0] TIMEOUT_RESET = 16'd200;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_CSUM_ERR = 2'd1,
    ST_TIMEOUT  = 2'd2
  } status_t;

  function automatic logic [10:0] dshot_code(input logic [15:0] thr);
    logic [15:0] v;
    begin
      v = 16'd0;
      if (thr == NEUTRAL) begin
        v = 16'd0;
      end else if (thr > NEUTRAL && thr <= FORWARD_MAX) begin
        v = thr + FORWARD_SHIFT;
      end else if (thr < NEUTRAL) begin
        v = REVERSE_TOP - thr;
      end
      return v[10:0];
    end
  endfunction

endpackage
`default_nettype wire

>>> src/thruster_command_frame_receiver_unit.sv
`default_nettype none
// Thruster command frame receiver. Each input transfer carries either a received byte
// (tuser 0) or a millisecond tick (tuser 1). Frames are 0x5A, one little-endian 16-bit
// throttle per motor, then an XOR checksum of all earlier bytes. A good frame commits the
// throttles and gives one result per motor, a bad checksum one error result, and a
// tick count beyond timeout_ticks (written through cfg_we/cfg_wdata, reset 200) forces all
// throttles to neutral and gives one result per motor, once until the next good frame.
// An input that causes results waits while an earlier burst is still being sent, and the
// single output register steps through the motors, one result per accepted transfer.
module thruster_command_frame_receiver_unit
  import tcfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte
  input  wire logic        s_tuser,   // req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status[1:0], motor_index[4:2], throttle_raw[20:5], dshot_value[31:21], idle flag[32]
  output logic [39:0]      m_tdata,
  output logic             m_tlast,   // last_of_run
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  logic [15:0]      timeout_ticks;
  logic [POS_W-1:0] byte_position;
  logic [7:0]       running_xor;
  logic [7:0]       low_byte_hold;
  logic [15:0]      staged_throttles [MOTOR_COUNT];
  logic [15:0]      committed_throttles [MOTOR_COUNT];
  logic [15:0]      idle_tick_count;
  logic             timed_out_flag;

  logic             out_valid;
  logic             out_err;
  status_t          out_status;
  logic [IDX_W-1:0] out_idx;

  logic [15:0]      tick_next;
  logic             is_tick;
  logic             at_start;
  logic             in_body;
  logic             csum_ok;
  logic             do_timeout;
  logic             emit;
  logic             accept;
  logic             out_last;
  logic             out_xfer;
  logic [IDX_W-1:0] stage_idx;
  logic             motors_idle;
  logic [15:0]      cur_thr;

  localparam logic [POS_W-1:0] BODY_END = POS_W'(2 * MOTOR_COUNT);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MOTOR_COUNT - 1);

  assign is_tick    = (s_tuser == REQ_TICK);
  assign tick_next  = (idle_tick_count < COUNT_MAX) ? idle_tick_count + 16'd1 : idle_tick_count;
  assign do_timeout = is_tick && (tick_next > timeout_ticks) && !timed_out_flag;
  assign at_start   = (byte_position == '0);
  assign in_body    = !at_start && (byte_position <= BODY_END);
  assign csum_ok    = (s_tdata == running_xor);
  assign emit       = do_timeout || (!is_tick && !at_start && !in_body);
  assign stage_idx  = IDX_W'((byte_position >> 1) - POS_W'(1));

  assign out_last = out_err || (out_idx == IDX_LAST);
  assign out_xfer = out_valid && m_tready;
  assign s_tready = !out_valid || !emit || (m_tready && out_last);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    motors_idle = 1'b1;
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      if (committed_throttles[i] != NEUTRAL) motors_idle = 1'b0;
    end
  end

  assign cur_thr = out_err ? 16'd0 : committed_throttles[out_idx];

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {7'd0, motors_idle, (out_err ? 11'd0 : dshot_code(cur_thr)), cur_thr,
                     (out_err ? 3'd0 : 3'(out_idx)), out_status};

  // staged throttles need no reset
  always_ff @(posedge clk) begin
    if (accept && !is_tick && in_body && !byte_position[0]) begin
      staged_throttles[stage_idx] <= {s_tdata, low_byte_hold};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks   <= TIMEOUT_RESET;
      byte_position   <= '0;
      running_xor     <= '0;
      low_byte_hold   <= '0;
      idle_tick_count <= '0;
      timed_out_flag  <= 1'b0;
      out_valid       <= 1'b0;
      out_err         <= 1'b0;
      out_status      <= ST_ACCEPTED;
      out_idx         <= '0;
      for (int i = 0; i < MOTOR_COUNT; i++) committed_throttles[i] <= NEUTRAL;
    end else begin
      if (cfg_we) timeout_ticks <= cfg_wdata;

      if (out_xfer) begin
        if (!out_last) out_idx <= out_idx + IDX_W'(1);
        else if (!(accept && emit)) out_valid <= 1'b0;
      end

      if (accept) begin
        if (is_tick) begin
          idle_tick_count <= tick_next;
          if (do_timeout) begin
            timed_out_flag <= 1'b1;
            byte_position  <= '0;
            running_xor    <= '0;
            for (int i = 0; i < MOTOR_COUNT; i++) committed_throttles[i] <= NEUTRAL;
            out_valid  <= 1'b1;
            out_err    <= 1'b0;
            out_status <= ST_TIMEOUT;
            out_idx    <= '0;
          end
        end else if (at_start) begin
          if (s_tdata == FRAME_START) begin
            running_xor   <= s_tdata;
            byte_position <= POS_W'(1);
          end
        end else if (in_body) begin
          if (byte_position[0]) low_byte_hold <= s_tdata;
          running_xor   <= running_xor ^ s_tdata;
          byte_position <= byte_position + POS_W'(1);
        end else begin
          // checksum byte
          byte_position <= '0;
          running_xor   <= '0;
          out_valid     <= 1'b1;
          out_idx       <= '0;
          if (csum_ok) begin
            for (int i = 0; i < MOTOR_COUNT; i++) committed_throttles[i] <= staged_throttles[i];
            idle_tick_count <= '0;
            timed_out_flag  <= 1'b0;
            out_err         <= 1'b0;
            out_status      <= ST_ACCEPTED;
          end else begin
            out_err    <= 1'b1;
            out_status <= ST_CSUM_ERR;
          end
        end
      end
    end
  end

  // an error result is always a run of one
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_err) |-> (m_tlast && out_status == ST_CSUM_ERR))
    else $error("error result not a single transfer");

  // a burst steps through the motors one transfer at a time
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && !out_last) |=> (out_valid && out_idx == $past(out_idx) + IDX_W'(1)))
    else $error("motor index did not advance");

  // timeout results carry neutral throttles
  a_timeout_neutral: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == ST_TIMEOUT) |-> (m_tdata[20:5] == NEUTRAL && m_tdata[32]))
    else $error("timeout result not neutral");

  // no result-producing input is taken while a burst still has results to send
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (accept && emit && out_valid) |-> (m_tready && out_last))
    else $error("burst overrun");

endmodule
`default_nettype wire
